>>> rtl/fssm_pkg.sv
// Package for the feed sequence and statistics monitor.
// Holds operation codes, statistic indexes and reset constants.
// No dependencies.
package fssm_pkg;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    localparam int unsigned NUM_VALUES   = 4;
    localparam int unsigned NUM_COUNTERS = 10;
    localparam int unsigned STAT_W       = 6;

    // configuration register indexes
    localparam logic [1:0] CFG_COLUMN_MASK = 2'd0;
    localparam logic [1:0] CFG_SHORT_GAP   = 2'd1;
    localparam logic [1:0] CFG_LONG_GAP    = 2'd2;

    // event counter slots
    localparam int unsigned EV_PUSHED   = 0;
    localparam int unsigned EV_SHORT    = 1;
    localparam int unsigned EV_LONG     = 2;
    localparam int unsigned EV_BACK     = 3;
    localparam int unsigned EV_OVERLAP  = 4;
    localparam int unsigned EV_IDGAP    = 5;
    localparam int unsigned EV_REVERSED = 6;
    localparam int unsigned EV_NULL_TS  = 7;
    localparam int unsigned EV_NULL_FID = 8;
    localparam int unsigned EV_NULL_LID = 9;

    // statistic index map
    localparam logic [STAT_W-1:0] ST_TIME_MIN  = 6'd0;
    localparam logic [STAT_W-1:0] ST_TIME_MAX  = 6'd1;
    localparam logic [STAT_W-1:0] ST_LARGE_GAP = 6'd2;
    localparam logic [STAT_W-1:0] ST_EV_FIRST  = 6'd3;
    localparam logic [STAT_W-1:0] ST_EV_LAST   = 6'd12;
    localparam logic [STAT_W-1:0] ST_VAL_FIRST = 6'd13;
    localparam logic [STAT_W-1:0] ST_VAL_LAST  = 6'd32;

    localparam logic [63:0] SMAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SMIN     = 64'h8000_0000_0000_0000;
    localparam logic [62:0] SHORT_RST = 63'd100000000;
    localparam logic [62:0] LONG_RST  = 63'd1000000000;
    localparam logic [5:0]  MASK_RST  = 6'd63;

    // saturating signed 64-bit add
    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a + b;
        if ((a[63] == b[63]) && (r[63] != a[63]))
            return a[63] ? SMIN : SMAX;
        return r;
    endfunction

endpackage

>>> rtl/feed_sequence_and_stats_monitor.sv
// Top level of the feed sequence and statistics monitor.
// Takes its codes and constants from fssm_pkg.
//
// One result per transfer, one transfer per cycle: all updates for a
// record are compares and adds done in the single register stage between
// input acceptance and the result register; a result shows in the next
// cycle, and one record per clock is sustained while i_stall is low.
module feed_sequence_and_stats_monitor
    import fssm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [62:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [63:0] i_timestamp,
    input  logic [63:0] i_first_id,
    input  logic [63:0] i_last_id,
    input  logic [63:0] i_bid_price,
    input  logic [63:0] i_bid_quantity,
    input  logic [63:0] i_ask_price,
    input  logic [63:0] i_ask_quantity,
    input  logic [5:0]  i_stat_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_stat_value,
    output logic        o_short_gap_hit,
    output logic        o_long_gap_hit,
    output logic        o_time_backwards,
    output logic        o_id_overlap_hit,
    output logic        o_id_gap_hit,
    output logic        o_ids_reversed
);

    logic [5:0]  r_mask;
    logic [62:0] r_short, r_long;

    logic [63:0] r_prev_time, n_prev_time;
    logic        r_prev_tv, n_prev_tv;
    logic [63:0] r_prev_lid, n_prev_lid;
    logic        r_prev_iv, n_prev_iv;
    logic [63:0] r_tmin, n_tmin, r_tmax, n_tmax, r_lgap, n_lgap;
    logic [63:0] r_ev   [NUM_COUNTERS];
    logic [63:0] n_ev   [NUM_COUNTERS];
    logic [63:0] r_vmin [NUM_VALUES];
    logic [63:0] n_vmin [NUM_VALUES];
    logic [63:0] r_vmax [NUM_VALUES];
    logic [63:0] n_vmax [NUM_VALUES];
    logic [63:0] r_vcnt [NUM_VALUES];
    logic [63:0] n_vcnt [NUM_VALUES];
    logic [63:0] r_vzero[NUM_VALUES];
    logic [63:0] n_vzero[NUM_VALUES];
    logic [63:0] r_vsum [NUM_VALUES];
    logic [63:0] n_vsum [NUM_VALUES];

    logic [63:0] r_stat, n_stat;
    logic [5:0]  r_flags, n_flags;
    logic        r_out_valid;

    logic        take;
    logic [63:0] vals  [NUM_VALUES];
    logic [3:0]  vpres;

    // output register refills when empty or taken
    assign o_stall = r_out_valid && i_stall;
    assign take    = i_valid && !o_stall;

    assign vals[0] = i_bid_price;
    assign vals[1] = i_bid_quantity;
    assign vals[2] = i_ask_price;
    assign vals[3] = i_ask_quantity;
    assign vpres   = {r_mask[5], r_mask[5], r_mask[4], r_mask[3]};

    // compute next statistics and result for the current transfer
    always_comb begin
        logic        back;
        logic [63:0] gap;
        logic [4:0]  vi;
        logic [2:0]  k;
        logic [1:0]  v;
        n_prev_time = r_prev_time;
        n_prev_tv   = r_prev_tv;
        n_prev_lid  = r_prev_lid;
        n_prev_iv   = r_prev_iv;
        n_tmin      = r_tmin;
        n_tmax      = r_tmax;
        n_lgap      = r_lgap;
        n_ev        = r_ev;
        n_vmin      = r_vmin;
        n_vmax      = r_vmax;
        n_vcnt      = r_vcnt;
        n_vzero     = r_vzero;
        n_vsum      = r_vsum;
        n_stat      = '0;
        n_flags     = '0;
        back        = 1'b0;
        gap         = '0;
        vi          = '0;
        k           = '0;
        v           = '0;
        case (t_op'(i_operation))
            OP_READ: begin
                if (i_stat_index == ST_TIME_MIN)
                    n_stat = r_tmin;
                else if (i_stat_index == ST_TIME_MAX)
                    n_stat = r_tmax;
                else if (i_stat_index == ST_LARGE_GAP)
                    n_stat = r_lgap;
                else if (i_stat_index <= ST_EV_LAST)
                    n_stat = r_ev[4'(i_stat_index - ST_EV_FIRST)];
                else if (i_stat_index <= ST_VAL_LAST) begin
                    vi = 5'(i_stat_index - ST_VAL_FIRST);
                    // split into value and item with a small compare chain
                    if (vi >= 5'd15) begin v = 2'd3; k = 3'(vi - 5'd15); end
                    else if (vi >= 5'd10) begin v = 2'd2; k = 3'(vi - 5'd10); end
                    else if (vi >= 5'd5) begin v = 2'd1; k = 3'(vi - 5'd5); end
                    else begin v = 2'd0; k = 3'(vi); end
                    case (k)
                        3'd0:    n_stat = r_vcnt[v];
                        3'd1:    n_stat = r_vmin[v];
                        3'd2:    n_stat = r_vmax[v];
                        3'd3:    n_stat = r_vzero[v];
                        default: n_stat = r_vsum[v];
                    endcase
                end
            end
            OP_CLEAR: begin
                n_prev_time = '0;
                n_prev_tv   = 1'b0;
                n_prev_lid  = '0;
                n_prev_iv   = 1'b0;
                n_tmin      = SMAX;
                n_tmax      = SMIN;
                n_lgap      = '0;
                for (int c = 0; c < NUM_COUNTERS; c++) n_ev[c] = '0;
                for (int c = 0; c < NUM_VALUES; c++) begin
                    n_vmin[c]  = SMAX;
                    n_vmax[c]  = SMIN;
                    n_vcnt[c]  = '0;
                    n_vzero[c] = '0;
                    n_vsum[c]  = '0;
                end
            end
            OP_PUSH: begin
                n_ev[EV_PUSHED] = r_ev[EV_PUSHED] + 64'd1;
                // timestamp column
                if (r_mask[0]) begin
                    if ($signed(i_timestamp) < $signed(r_tmin)) n_tmin = i_timestamp;
                    if ($signed(r_tmax) < $signed(i_timestamp)) n_tmax = i_timestamp;
                    if (r_prev_tv) begin
                        back = $signed(i_timestamp) < $signed(r_prev_time);
                        gap  = back ? 64'd0 : i_timestamp - r_prev_time;
                        if (gap > r_lgap) n_lgap = gap;
                        if (gap >= {1'b0, r_short}) begin
                            n_ev[EV_SHORT] = r_ev[EV_SHORT] + 64'd1;
                            n_flags[0] = 1'b1;
                        end
                        if (gap >= {1'b0, r_long}) begin
                            n_ev[EV_LONG] = r_ev[EV_LONG] + 64'd1;
                            n_flags[1] = 1'b1;
                        end
                        if (back) begin
                            n_ev[EV_BACK] = r_ev[EV_BACK] + 64'd1;
                            n_flags[2] = 1'b1;
                        end
                    end
                    n_prev_time = i_timestamp;
                    n_prev_tv   = 1'b1;
                end else begin
                    n_ev[EV_NULL_TS] = r_ev[EV_NULL_TS] + 64'd1;
                end
                if (!r_mask[1]) n_ev[EV_NULL_FID] = r_ev[EV_NULL_FID] + 64'd1;
                if (!r_mask[2]) n_ev[EV_NULL_LID] = r_ev[EV_NULL_LID] + 64'd1;
                // sequence id checks
                if (r_mask[2:1] == 2'b11) begin
                    if (i_last_id < i_first_id) begin
                        n_ev[EV_REVERSED] = r_ev[EV_REVERSED] + 64'd1;
                        n_flags[5] = 1'b1;
                    end
                    if (r_prev_iv) begin
                        if (i_first_id <= r_prev_lid) begin
                            n_ev[EV_OVERLAP] = r_ev[EV_OVERLAP] + 64'd1;
                            n_flags[3] = 1'b1;
                        end
                        if (i_first_id > r_prev_lid + 64'd1) begin
                            n_ev[EV_IDGAP] = r_ev[EV_IDGAP] + 64'd1;
                            n_flags[4] = 1'b1;
                        end
                    end
                    n_prev_lid = i_last_id;
                    n_prev_iv  = 1'b1;
                end
                // value lanes
                for (int c = 0; c < NUM_VALUES; c++) begin
                    if (vpres[c]) begin
                        if ($signed(vals[c]) < $signed(r_vmin[c])) n_vmin[c] = vals[c];
                        if ($signed(r_vmax[c]) < $signed(vals[c])) n_vmax[c] = vals[c];
                        if (vals[c] == 64'd0) n_vzero[c] = r_vzero[c] + 64'd1;
                        n_vcnt[c] = r_vcnt[c] + 64'd1;
                        n_vsum[c] = sat_add(r_vsum[c], vals[c]);
                    end
                end
            end
            default: ;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= MASK_RST;
            r_short <= SHORT_RST;
            r_long  <= LONG_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COLUMN_MASK: r_mask  <= i_cfg_data[5:0];
                CFG_SHORT_GAP:   r_short <= i_cfg_data;
                CFG_LONG_GAP:    r_long  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // statistics state, advanced on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_time <= '0;
            r_prev_tv   <= 1'b0;
            r_prev_lid  <= '0;
            r_prev_iv   <= 1'b0;
            r_tmin      <= SMAX;
            r_tmax      <= SMIN;
            r_lgap      <= '0;
            for (int c = 0; c < NUM_COUNTERS; c++) r_ev[c] <= '0;
            for (int c = 0; c < NUM_VALUES; c++) begin
                r_vmin[c]  <= SMAX;
                r_vmax[c]  <= SMIN;
                r_vcnt[c]  <= '0;
                r_vzero[c] <= '0;
                r_vsum[c]  <= '0;
            end
        end else if (take) begin
            r_prev_time <= n_prev_time;
            r_prev_tv   <= n_prev_tv;
            r_prev_lid  <= n_prev_lid;
            r_prev_iv   <= n_prev_iv;
            r_tmin      <= n_tmin;
            r_tmax      <= n_tmax;
            r_lgap      <= n_lgap;
            r_ev        <= n_ev;
            r_vmin      <= n_vmin;
            r_vmax      <= n_vmax;
            r_vcnt      <= n_vcnt;
            r_vzero     <= n_vzero;
            r_vsum      <= n_vsum;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_stat  <= n_stat;
            r_flags <= n_flags;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_stat_value     = r_stat;
    assign o_short_gap_hit  = r_flags[0];
    assign o_long_gap_hit   = r_flags[1];
    assign o_time_backwards = r_flags[2];
    assign o_id_overlap_hit = r_flags[3];
    assign o_id_gap_hit     = r_flags[4];
    assign o_ids_reversed   = r_flags[5];

endmodule

>>> rtl/fssm_checker.sv
// Port-level checks for the feed sequence and statistics monitor.
// Uses fssm_pkg codes; bound to the top level below.
module fssm_checker
    import fssm_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [1:0]  i_operation,
    input logic        o_valid,
    input logic        i_stall,
    input logic [63:0] o_stat_value,
    input logic        o_short_gap_hit,
    input logic        o_long_gap_hit,
    input logic        o_time_backwards,
    input logic        o_id_overlap_hit,
    input logic        o_id_gap_hit,
    input logic        o_ids_reversed
);

    // an accepted item shows a result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_valid)
        else $error("accepted item gave no result");

    // stall only while a result is held back
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("stall without pending result");

    // a non-push gives no flags
    a_no_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_operation != OP_PUSH)) |=>
        !(o_short_gap_hit || o_long_gap_hit || o_time_backwards ||
          o_id_overlap_hit || o_id_gap_hit || o_ids_reversed))
        else $error("flags set on non-push");

    // a stalled result stays offered
    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("stalled result dropped");

    // a held result does not change
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(o_stat_value))
        else $error("stalled result changed");

endmodule

bind feed_sequence_and_stats_monitor fssm_checker u_fssm_checker (.*);
